### src/cbps_pkg.sv
// shared types, codes and helpers for the cb prefix bit and shift unit
package cbps_pkg;

	localparam int NUM_REGS  = 7;
	localparam int SLOT_W    = 3;

	localparam logic [1:0] GRP_SHIFT = 2'd0;
	localparam logic [1:0] GRP_BIT   = 2'd1;
	localparam logic [1:0] GRP_RES   = 2'd2;
	localparam logic [1:0] GRP_SET   = 2'd3;

	localparam logic [2:0] KIND_RLC  = 3'd0;
	localparam logic [2:0] KIND_RRC  = 3'd1;
	localparam logic [2:0] KIND_RL   = 3'd2;
	localparam logic [2:0] KIND_RR   = 3'd3;
	localparam logic [2:0] KIND_SLA  = 3'd4;
	localparam logic [2:0] KIND_SRA  = 3'd5;
	localparam logic [2:0] KIND_SWAP = 3'd6;
	localparam logic [2:0] KIND_SRL  = 3'd7;

	localparam logic [2:0] MEM_COLUMN  = 3'd6;
	localparam logic [2:0] FLAGS_INDEX = 3'd6;
	localparam logic [2:0] SEL_A       = 3'd7;
	localparam logic [SLOT_W-1:0] SLOT_A = 3'd6;

	localparam logic [7:0] TOP_BIT_MASK     = 8'b1000_0000;
	localparam logic [7:0] HIGH_NIBBLE_MASK = 8'b1111_0000;
	localparam logic [7:0] LOW_NIBBLE_MASK  = 8'b0000_1111;

	typedef struct packed {
		logic z;
		logic n;
		logic h;
		logic c;
	} flags_t;

	typedef struct packed {
		logic              reg_en;
		logic [SLOT_W-1:0] slot;
		logic [7:0]        data;
		logic              flag_en;
		flags_t            flags;
	} wr_req_t;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [2:0] sel);
		return (sel == SEL_A) ? SLOT_A : sel;
	endfunction

endpackage

### src/cb_prefix_bit_shift_unit.sv
// top level: input register, execute and result register around the kept registers
// Executes one CB-prefixed rotate/shift/swap, BIT, RES or SET opcode, or a
// register/flag load, per beat. An accepted beat is registered, executed
// against the register file while it is held in the input register and
// lands in the result register as it leaves; the unit sustains one beat
// per cycle unless out_ready stalls it. The register file and flags update
// as the beat leaves the input register, so back-to-back beats see each
// other's writes. Memory-operand opcodes change nothing and report unsupported.
module cb_prefix_bit_shift_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] opcode,
	input  logic [2:0] reg_index,
	input  logic [7:0] load_value,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] result_value,
	output logic       zero_flag,
	output logic       subtract_flag,
	output logic       half_carry_flag,
	output logic       carry_flag,
	output logic       unsupported
);
	import cbps_pkg::*;

	logic              valid_s1;
	logic              action_s1;
	logic [7:0]        opcode_s1;
	logic [2:0]        reg_index_s1;
	logic [7:0]        load_value_s1;
	logic              out_valid_q;
	logic [7:0]        result_q;
	flags_t            flags_res_q;
	logic              unsup_q;
	logic              advance;
	logic [SLOT_W-1:0] rd_slot;
	logic [7:0]        rd_data;
	flags_t            flags_cur;
	flags_t            flags_next;
	wr_req_t           wr;
	logic [7:0]        result_next;
	logic              unsup_next;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_s1     <= 1'b0;
			opcode_s1     <= 8'h00;
			reg_index_s1  <= 3'd0;
			load_value_s1 <= 8'h00;
			result_q      <= 8'h00;
			flags_res_q   <= '0;
			unsup_q       <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				action_s1     <= action;
				opcode_s1     <= opcode;
				reg_index_s1  <= reg_index;
				load_value_s1 <= load_value;
			end
			if (advance) begin
				result_q    <= result_next;
				flags_res_q <= flags_next;
				unsup_q     <= unsup_next;
			end
		end
	end

	cbps_alu u_alu (
		.action     (action_s1),
		.opcode     (opcode_s1),
		.reg_index  (reg_index_s1),
		.load_value (load_value_s1),
		.rd_data    (rd_data),
		.flags_in   (flags_cur),
		.rd_slot    (rd_slot),
		.wr         (wr),
		.result     (result_next),
		.flags_out  (flags_next),
		.unsup      (unsup_next)
	);

	cbps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (advance),
		.wr      (wr),
		.rd_slot (rd_slot),
		.rd_data (rd_data),
		.flags   (flags_cur)
	);

	assign out_valid       = out_valid_q;
	assign result_value    = result_q;
	assign zero_flag       = flags_res_q.z;
	assign subtract_flag   = flags_res_q.n;
	assign half_carry_flag = flags_res_q.h;
	assign carry_flag      = flags_res_q.c;
	assign unsupported     = unsup_q;

endmodule

### src/cbps_alu.sv
// combinational execute: shift, bit test, reset/set and register or flag load
module cbps_alu (
	input  logic                         action,
	input  logic [7:0]                   opcode,
	input  logic [2:0]                   reg_index,
	input  logic [7:0]                   load_value,
	input  logic [7:0]                   rd_data,
	input  cbps_pkg::flags_t             flags_in,
	output logic [cbps_pkg::SLOT_W-1:0]  rd_slot,
	output cbps_pkg::wr_req_t            wr,
	output logic [7:0]                   result,
	output cbps_pkg::flags_t             flags_out,
	output logic                         unsup
);
	import cbps_pkg::*;

	logic [2:0] col;
	logic [2:0] sel;
	logic [1:0] grp;
	logic [7:0] mask;
	logic [7:0] sh_res;
	logic       sh_c;

	assign col  = opcode[2:0];
	assign sel  = opcode[5:3];
	assign grp  = opcode[7:6];
	assign mask = 8'h01 << sel;
	assign rd_slot = slot_of(action ? reg_index : col);

	always_comb begin
		unique case (sel)
			KIND_RLC: begin
				sh_c   = rd_data[7];
				sh_res = {rd_data[6:0], rd_data[7]};
			end
			KIND_RRC: begin
				sh_c   = rd_data[0];
				sh_res = {rd_data[0], rd_data[7:1]};
			end
			KIND_RL: begin
				sh_c   = rd_data[7];
				sh_res = {rd_data[6:0], flags_in.c};
			end
			KIND_RR: begin
				sh_c   = rd_data[0];
				sh_res = {flags_in.c, rd_data[7:1]};
			end
			KIND_SLA: begin
				sh_c   = rd_data[7];
				sh_res = {rd_data[6:0], 1'b0};
			end
			KIND_SRA: begin
				sh_c   = rd_data[0];
				sh_res = (rd_data >> 1) | (rd_data & TOP_BIT_MASK);
			end
			KIND_SWAP: begin
				sh_c   = 1'b0;
				sh_res = ((rd_data & HIGH_NIBBLE_MASK) >> 4) | ((rd_data & LOW_NIBBLE_MASK) << 4);
			end
			KIND_SRL: begin
				sh_c   = rd_data[0];
				sh_res = {1'b0, rd_data[7:1]};
			end
			default: begin
				sh_c   = 1'b0;
				sh_res = 8'h00;
			end
		endcase
	end

	always_comb begin
		wr        = '0;
		result    = 8'h00;
		flags_out = flags_in;
		unsup     = 1'b0;
		if (action) begin
			if (reg_index == FLAGS_INDEX) begin
				wr.flag_en = 1'b1;
				wr.flags   = flags_t'(load_value[7:4]);
				flags_out  = flags_t'(load_value[7:4]);
				result     = {load_value[7:4], 4'h0};
			end else begin
				wr.reg_en = 1'b1;
				wr.slot   = rd_slot;
				wr.data   = load_value;
				result    = load_value;
			end
		end else if (col == MEM_COLUMN) begin
			unsup = 1'b1;
		end else begin
			unique case (grp)
				GRP_SHIFT: begin
					result     = sh_res;
					wr.flag_en = 1'b1;
					wr.flags   = '{z: (sh_res == 8'h00), n: 1'b0, h: 1'b0, c: sh_c};
				end
				GRP_BIT: begin
					result     = rd_data;
					wr.flag_en = 1'b1;
					wr.flags   = '{z: ~|(rd_data & mask), n: 1'b0, h: 1'b1, c: flags_in.c};
				end
				GRP_RES: result = rd_data & ~mask;
				GRP_SET: result = rd_data | mask;
				default: result = rd_data;
			endcase
			wr.reg_en = 1'b1;
			wr.slot   = rd_slot;
			wr.data   = result;
			if (wr.flag_en)
				flags_out = wr.flags;
		end
	end

endmodule

### src/cbps_regs.sv
// kept register file b c d e h l a and the four flags
module cbps_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         commit,
	input  cbps_pkg::wr_req_t            wr,
	input  logic [cbps_pkg::SLOT_W-1:0]  rd_slot,
	output logic [7:0]                   rd_data,
	output cbps_pkg::flags_t             flags
);
	import cbps_pkg::*;

	logic [7:0] regs_q [NUM_REGS];
	flags_t     flags_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				regs_q[i] <= 8'h00;
			flags_q <= '0;
		end else if (commit) begin
			if (wr.reg_en)
				regs_q[wr.slot] <= wr.data;
			if (wr.flag_en)
				flags_q <= wr.flags;
		end
	end

	assign rd_data = regs_q[rd_slot];
	assign flags   = flags_q;

endmodule
